[rtl/core/srps_pkg.sv]
// Shared types and constants for the sorted prefix range search block.
// Holds field widths, command codes and the controller/datapath structs.
// Depends on nothing.
package srps_pkg;

  localparam int unsigned DEPTH_DEF         = 1024;
  localparam int unsigned KEY_BYTES_DEF     = 8;
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned MAX_LISTED_DEF    = 63;

  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned PREFIX_W   = 64;
  localparam int unsigned TEXT_POS_W = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_LEN_W  = 4;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned OUT_POS_W  = 32;
  localparam int unsigned LIST_W     = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic KIND_SUMMARY  = 1'b0;
  localparam logic KIND_POSITION = 1'b1;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_MID,
    ADDR_RIGHT,
    ADDR_WALK
  } addr_sel_e;

  typedef struct packed {
    logic      load_we;
    logic      cap_query;
    logic      pfx_rd;
    addr_sel_e addr_sel;
    logic      clr_match;
    logic      set_first_zero;
    logic      set_range;
    logic      bs_upd;
    logic      set_first_right;
    logic      walk_step;
    logic      pos_rd;
    logic      out_sum;
    logic      out_pos;
  } srps_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic key_le;
    logic tbl_lt;
    logic eq;
    logic span_gt1;
    logic walk_end;
    logic list_empty;
    logic list_last;
    logic out_free;
  } srps_sts_t;

endpackage

[rtl/core/srps_dp.sv]
// Datapath of the sorted prefix range search: prefix and position memories,
// search bounds, match counter and the output register.
// Depends on srps_pkg; driven by srps_ctrl.
module srps_dp #(
  parameter int unsigned DEPTH         = srps_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES     = srps_pkg::KEY_BYTES_DEF,
  parameter int unsigned POSITION_BITS = srps_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_LISTED    = srps_pkg::MAX_LISTED_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  srps_pkg::srps_cmd_t                cmd_i,
  output srps_pkg::srps_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [srps_pkg::COUNT_W-1:0]       cfg_wdata_i,
  input  logic [srps_pkg::INDEX_W-1:0]       entry_index_i,
  input  logic [srps_pkg::PREFIX_W-1:0]      entry_prefix_i,
  input  logic [srps_pkg::TEXT_POS_W-1:0]    text_position_i,
  input  logic [srps_pkg::KEY_W-1:0]         search_key_i,
  input  logic [srps_pkg::KEY_LEN_W-1:0]     key_length_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               kind_o,
  output logic                               found_o,
  output logic [srps_pkg::INDEX_W-1:0]       first_index_o,
  output logic [srps_pkg::COUNT_W-1:0]       match_count_o,
  output logic [srps_pkg::OUT_POS_W-1:0]     position_out_o,
  output logic                               truncated_o,
  output logic                               last_o
);
  import srps_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = 8 * KEY_BYTES;

  logic [KW-1:0]            pfx_mem [DEPTH];
  logic [POSITION_BITS-1:0] pos_mem [DEPTH];
  logic [KW-1:0]            pfx_rd_q;
  logic [POSITION_BITS-1:0] pos_rd_q;

  logic [COUNT_W-1:0] entry_count_q;
  logic [KW-1:0]      key_q, mask_q;
  logic [CW-1:0]      n_q, i_q, cnt_q;
  logic [AW-1:0]      l_q, r_q, f_q;
  logic [LIST_W-1:0]  k_q;

  logic [KEY_LEN_W-1:0] len_c;
  logic [KW-1:0]        mask_c;
  logic [31:0]          ec_w;
  logic [CW-1:0]        n_c, n_m1;
  logic [AW:0]          lr_sum;
  logic [AW-1:0]        mid, pfx_addr, pos_addr, waddr;
  logic                 load_ok;
  logic [KW-1:0]        tbl_m;
  logic                 trunc;
  logic [LIST_W-1:0]    listed;
  logic                 out_free;

  always_comb begin
    len_c = (key_length_i > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : key_length_i;
    for (int j = 0; j < KEY_BYTES; j++) begin
      mask_c[KW-1-8*j -: 8] = (KEY_LEN_W'(j) < len_c) ? 8'hFF : 8'h00;
    end
  end

  assign ec_w    = 32'(entry_count_q);
  assign n_c     = (ec_w > 32'(DEPTH)) ? CW'(DEPTH) : CW'(ec_w);
  assign n_m1    = n_q - CW'(1);
  assign lr_sum  = {1'b0, l_q} + {1'b0, r_q};
  assign mid     = lr_sum[AW:1];
  assign load_ok = 32'(entry_index_i) < 32'(DEPTH);
  assign waddr   = AW'(entry_index_i);
  assign pos_addr = f_q + AW'(k_q);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_ZERO:  pfx_addr = '0;
      ADDR_LAST:  pfx_addr = AW'(n_m1);
      ADDR_MID:   pfx_addr = mid;
      ADDR_RIGHT: pfx_addr = r_q;
      ADDR_WALK:  pfx_addr = AW'(i_q);
      default:    pfx_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      pfx_mem[waddr] <= KW'(entry_prefix_i);
      pos_mem[waddr] <= POSITION_BITS'(text_position_i);
    end
    if (cmd_i.pfx_rd) begin
      pfx_rd_q <= pfx_mem[pfx_addr];
    end
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[pos_addr];
    end
  end

  assign tbl_m  = pfx_rd_q & mask_q;
  assign trunc  = 32'(cnt_q) > 32'(MAX_LISTED);
  assign listed = trunc ? LIST_W'(MAX_LISTED) : LIST_W'(cnt_q);
  assign out_free = !out_valid_o || out_ready_i;

  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.key_le     = (key_q <= tbl_m);
  assign sts_o.tbl_lt     = (tbl_m < key_q);
  assign sts_o.eq         = (key_q == tbl_m);
  assign sts_o.span_gt1   = ((r_q - l_q) > AW'(1));
  assign sts_o.walk_end   = (i_q == n_q);
  assign sts_o.list_empty = (listed == '0);
  assign sts_o.list_last  = (LIST_W'(k_q + LIST_W'(1)) == listed);
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_query) begin
      key_q  <= KW'(search_key_i) & mask_c;
      mask_q <= mask_c;
      n_q    <= n_c;
    end
    if (cmd_i.set_range) begin
      l_q <= '0;
      r_q <= AW'(n_m1);
    end
    if (cmd_i.bs_upd) begin
      if (sts_o.key_le) begin
        r_q <= mid;
      end else begin
        l_q <= mid;
      end
    end
    if (cmd_i.clr_match) begin
      f_q   <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.set_first_zero) begin
      f_q   <= '0;
      i_q   <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.set_first_right) begin
      f_q   <= r_q;
      i_q   <= CW'(r_q);
      cnt_q <= '0;
    end
    if (cmd_i.walk_step) begin
      i_q   <= i_q + CW'(1);
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.out_sum) begin
      k_q <= '0;
    end else if (cmd_i.out_pos) begin
      k_q <= k_q + LIST_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_sum || cmd_i.out_pos) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sum) begin
      kind_o         <= KIND_SUMMARY;
      found_o        <= (cnt_q != '0);
      first_index_o  <= INDEX_W'(f_q);
      match_count_o  <= COUNT_W'(cnt_q);
      position_out_o <= '0;
      truncated_o    <= trunc;
      last_o         <= sts_o.list_empty;
    end else if (cmd_i.out_pos) begin
      kind_o         <= KIND_POSITION;
      found_o        <= 1'b1;
      first_index_o  <= INDEX_W'(f_q);
      match_count_o  <= COUNT_W'(cnt_q);
      position_out_o <= OUT_POS_W'(pos_rd_q);
      truncated_o    <= trunc;
      last_o         <= sts_o.list_last;
    end
  end

endmodule

[rtl/core/srps_ctrl.sv]
// Controller of the sorted prefix range search: sequences loads, the binary
// search, the match walk and the result listing.
// Depends on srps_pkg; drives srps_dp through command and status structs.
module srps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                command_i,
  output logic                in_ready_o,
  input  srps_pkg::srps_sts_t sts_i,
  output srps_pkg::srps_cmd_t cmd_o
);
  import srps_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_CK0   = 4'd2;
  localparam logic [3:0] S_CKN   = 4'd3;
  localparam logic [3:0] S_BS    = 4'd4;
  localparam logic [3:0] S_BSC   = 4'd5;
  localparam logic [3:0] S_CKR   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_WALKC = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_LRD   = 4'd10;
  localparam logic [3:0] S_LOUT  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.addr_sel = ADDR_ZERO;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.cap_query = 1'b1;
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        if (sts_i.n_zero) begin
          cmd_o.clr_match = 1'b1;
          state_d = S_SUM;
        end else begin
          cmd_o.pfx_rd = 1'b1;
          cmd_o.addr_sel = ADDR_ZERO;
          state_d = S_CK0;
        end
      end
      S_CK0: begin
        if (sts_i.key_le) begin
          cmd_o.set_first_zero = 1'b1;
          state_d = S_WALK;
        end else begin
          cmd_o.pfx_rd = 1'b1;
          cmd_o.addr_sel = ADDR_LAST;
          state_d = S_CKN;
        end
      end
      S_CKN: begin
        if (sts_i.tbl_lt) begin
          cmd_o.clr_match = 1'b1;
          state_d = S_SUM;
        end else begin
          cmd_o.set_range = 1'b1;
          state_d = S_BS;
        end
      end
      S_BS: begin
        cmd_o.pfx_rd = 1'b1;
        if (sts_i.span_gt1) begin
          cmd_o.addr_sel = ADDR_MID;
          state_d = S_BSC;
        end else begin
          cmd_o.addr_sel = ADDR_RIGHT;
          state_d = S_CKR;
        end
      end
      S_BSC: begin
        cmd_o.bs_upd = 1'b1;
        state_d = S_BS;
      end
      S_CKR: begin
        if (sts_i.eq) begin
          cmd_o.set_first_right = 1'b1;
          state_d = S_WALK;
        end else begin
          cmd_o.clr_match = 1'b1;
          state_d = S_SUM;
        end
      end
      S_WALK: begin
        if (sts_i.walk_end) begin
          state_d = S_SUM;
        end else begin
          cmd_o.pfx_rd = 1'b1;
          cmd_o.addr_sel = ADDR_WALK;
          state_d = S_WALKC;
        end
      end
      S_WALKC: begin
        if (sts_i.eq) begin
          cmd_o.walk_step = 1'b1;
          state_d = S_WALK;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.out_sum = 1'b1;
          state_d = sts_i.list_empty ? S_IDLE : S_LRD;
        end
      end
      S_LRD: begin
        cmd_o.pos_rd = 1'b1;
        state_d = S_LOUT;
      end
      S_LOUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_pos = 1'b1;
          state_d = sts_i.list_last ? S_IDLE : S_LRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/sorted_prefix_range_search.sv]
// Top level of the sorted prefix range search block.
// Instantiates srps_ctrl and srps_dp; depends on srps_pkg.
//
// Usage: a sorted table of key prefixes with one text position per entry is
// written by load requests (command 0) on the input channel; a load gives no
// result. A query request (command 1) brings a key and a key length. The
// block returns a summary result (kind 0) followed by one result per listed
// matching position (kind 1), at most MAX_LISTED of them, with last set on
// the final result of the query.
// The entry_count register sets how many entries queries search; write it
// through cfg_we_i and cfg_wdata_i only while no query is in flight.
// The prefix memory has one read port with a registered output. A query
// checks the first and last entries and, if needed, finds the first match
// by binary search; it then walks the matching entries until a probe shows
// a mismatch or the table ends, and sends the summary and one result per
// listed position.
// One request is worked on at a time; the next is taken once the last
// result of a query sits in the output register.
// If the receiver stalls, the result is held and the sequencer waits.
// Reset returns the block to idle, drops any pending result and sets
// entry_count to 1; table contents are undefined until loaded.
module sorted_prefix_range_search #(
  parameter int unsigned DEPTH         = srps_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BYTES     = srps_pkg::KEY_BYTES_DEF,
  parameter int unsigned POSITION_BITS = srps_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_LISTED    = srps_pkg::MAX_LISTED_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srps_pkg::COUNT_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [srps_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [srps_pkg::PREFIX_W-1:0]   entry_prefix_i,
  input  logic [srps_pkg::TEXT_POS_W-1:0] text_position_i,
  input  logic [srps_pkg::KEY_W-1:0]      search_key_i,
  input  logic [srps_pkg::KEY_LEN_W-1:0]  key_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic                            found_o,
  output logic [srps_pkg::INDEX_W-1:0]    first_index_o,
  output logic [srps_pkg::COUNT_W-1:0]    match_count_o,
  output logic [srps_pkg::OUT_POS_W-1:0]  position_out_o,
  output logic                            truncated_o,
  output logic                            last_o
);
  import srps_pkg::*;

  srps_cmd_t cmd;
  srps_sts_t sts;

  srps_ctrl u_srps_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srps_dp #(
    .DEPTH         (DEPTH),
    .KEY_BYTES     (KEY_BYTES),
    .POSITION_BITS (POSITION_BITS),
    .MAX_LISTED    (MAX_LISTED)
  ) u_srps_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_index_i   (entry_index_i),
    .entry_prefix_i  (entry_prefix_i),
    .text_position_i (text_position_i),
    .search_key_i    (search_key_i),
    .key_length_i    (key_length_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .found_o         (found_o),
    .first_index_o   (first_index_o),
    .match_count_o   (match_count_o),
    .position_out_o  (position_out_o),
    .truncated_o     (truncated_o),
    .last_o          (last_o)
  );

endmodule

[rtl/core/srps_checker.sv]
// Port-level checker for the sorted prefix range search block, with the
// bind statement that attaches it to the top level.
// Depends on srps_pkg and sorted_prefix_range_search.
module srps_checker #(
  parameter int unsigned MAX_LISTED = srps_pkg::MAX_LISTED_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           kind_i,
  input logic                           found_i,
  input logic [srps_pkg::INDEX_W-1:0]   first_index_i,
  input logic [srps_pkg::COUNT_W-1:0]   match_count_i,
  input logic [srps_pkg::OUT_POS_W-1:0] position_out_i,
  input logic                           truncated_i,
  input logic                           last_i
);
  import srps_pkg::*;

  // A stalled result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(position_out_i) && $stable(kind_i) && $stable(last_i)))
    else $error("result changed while stalled");

  // A summary without matches reports index zero and ends the query.
  a_none_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i == KIND_SUMMARY && !found_i) |->
      (last_i && match_count_i == '0 && first_index_i == '0))
    else $error("empty summary is inconsistent");

  // Position results only follow a successful search.
  a_pos_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && kind_i == KIND_POSITION) |-> (found_i && match_count_i != '0))
    else $error("position result without a match");

  // The truncation flag agrees with the reported match count.
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (truncated_i == (32'(match_count_i) > 32'(MAX_LISTED))))
    else $error("truncation flag disagrees with match count");

endmodule

bind sorted_prefix_range_search srps_checker #(
  .MAX_LISTED (MAX_LISTED)
) u_srps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_i         (kind_o),
  .found_i        (found_o),
  .first_index_i  (first_index_o),
  .match_count_i  (match_count_o),
  .position_out_i (position_out_o),
  .truncated_i    (truncated_o),
  .last_i         (last_o)
);

[bench/srps_listing_checker.sv]
`timescale 1ns / 100ps
// Checker for the sorted prefix range search block: watches the request, result
// and register ports, predicts every result row and compares it field by field.
// Depends on srps_pkg for widths and codes.
module srps_listing_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srps_pkg::COUNT_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            command_i,
  input  logic [srps_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [srps_pkg::PREFIX_W-1:0]   entry_prefix_i,
  input  logic [srps_pkg::TEXT_POS_W-1:0] text_position_i,
  input  logic [srps_pkg::KEY_W-1:0]      search_key_i,
  input  logic [srps_pkg::KEY_LEN_W-1:0]  key_length_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            kind_i,
  input  logic                            found_i,
  input  logic [srps_pkg::INDEX_W-1:0]    first_index_i,
  input  logic [srps_pkg::COUNT_W-1:0]    match_count_i,
  input  logic [srps_pkg::OUT_POS_W-1:0]  position_out_i,
  input  logic                            truncated_i,
  input  logic                            last_i,
  output int unsigned                     failures_o,
  output int unsigned                     pending_o
);
  import srps_pkg::*;

  typedef struct packed {
    logic                 kind;
    logic                 found;
    logic [INDEX_W-1:0]   first_index;
    logic [COUNT_W-1:0]   match_count;
    logic [OUT_POS_W-1:0] position;
    logic                 truncated;
    logic                 last;
  } search_row_t;

  logic [PREFIX_W-1:0]   prefix_copy [DEPTH_DEF];
  logic [TEXT_POS_W-1:0] position_copy [DEPTH_DEF];
  logic [COUNT_W-1:0]    entry_count_q;
  search_row_t           expected_rows [$];
  search_row_t           seen_row;
  search_row_t           want_row;
  int unsigned           failures;

  function automatic int prefix_order(input logic [63:0] a, input logic [63:0] b,
                                      input int unsigned len);
    logic [63:0] a_head;
    logic [63:0] b_head;
    if (len == 0) return 0;
    a_head = a >> (8 * (KEY_BYTES_DEF - len));
    b_head = b >> (8 * (KEY_BYTES_DEF - len));
    if (a_head < b_head) return -1;
    if (a_head > b_head) return 1;
    return 0;
  endfunction

  function automatic void predict_search(input logic [KEY_W-1:0] key,
                                         input logic [KEY_LEN_W-1:0] len_field);
    int unsigned n, len, first, lo, hi, mid, count, listed, i;
    bit          hit, walking;
    search_row_t row;
    n     = (entry_count_q > DEPTH_DEF) ? DEPTH_DEF : entry_count_q;
    len   = (len_field > KEY_BYTES_DEF) ? KEY_BYTES_DEF : len_field;
    hit   = 1'b0;
    first = 0;
    if (n > 0) begin
      if (prefix_order(key, prefix_copy[0], len) <= 0) begin
        hit = 1'b1;
      end else if (prefix_order(prefix_copy[n - 1], key, len) >= 0) begin
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (prefix_order(key, prefix_copy[mid], len) <= 0) hi = mid;
          else lo = mid;
        end
        if (prefix_order(key, prefix_copy[hi], len) == 0) begin
          first = hi;
          hit   = 1'b1;
        end
      end
    end
    count   = 0;
    i       = first;
    walking = hit;
    while (walking && i < n) begin
      if (prefix_order(key, prefix_copy[i], len) == 0) begin
        count++;
        i++;
      end else begin
        walking = 1'b0;
      end
    end
    if (count == 0) first = 0;
    listed = (count > MAX_LISTED_DEF) ? MAX_LISTED_DEF : count;

    row.kind        = KIND_SUMMARY;
    row.found       = (count > 0);
    row.first_index = INDEX_W'(first);
    row.match_count = COUNT_W'(count);
    row.position    = '0;
    row.truncated   = (count > MAX_LISTED_DEF);
    row.last        = (listed == 0);
    expected_rows.push_back(row);
    for (i = 0; i < listed; i++) begin
      row.kind     = KIND_POSITION;
      row.found    = 1'b1;
      row.position = position_copy[first + i];
      row.last     = (i + 1 == listed);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", label, want, seen);
      failures++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q = COUNT_W'(1);
      expected_rows.delete();
      failures = 0;
      failures_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_row = '{kind_i, found_i, first_index_i, match_count_i, position_out_i,
                     truncated_i, last_i};
        if (expected_rows.size() == 0) begin
          $error("Result arrived with no request waiting for it.");
          failures++;
        end else begin
          want_row = expected_rows.pop_front();
          check_field("kind", 32'(want_row.kind), 32'(seen_row.kind));
          check_field("found", 32'(want_row.found), 32'(seen_row.found));
          check_field("first_index", 32'(want_row.first_index),
                      32'(seen_row.first_index));
          check_field("match_count", 32'(want_row.match_count),
                      32'(seen_row.match_count));
          check_field("position_out", want_row.position, seen_row.position);
          check_field("truncated", 32'(want_row.truncated), 32'(seen_row.truncated));
          check_field("last", 32'(want_row.last), 32'(seen_row.last));
        end
      end
      if (cfg_we_i) entry_count_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (command_i == CMD_LOAD) begin
          prefix_copy[entry_index_i]   = entry_prefix_i;
          position_copy[entry_index_i] = text_position_i;
        end else begin
          predict_search(search_key_i, key_length_i);
        end
      end
      failures_o <= failures;
      pending_o <= expected_rows.size();
    end
  end

endmodule

[bench/sorted_prefix_range_search_test.sv]
`timescale 1ns / 100ps
// Top of the sorted prefix range search testbench: clock, reset, table loads,
// queries, receiver stalls and the verdict. Depends on srps_pkg, the block
// and srps_listing_checker.
module sorted_prefix_range_search_test;
  import srps_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [COUNT_W-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  command_i;
  logic [INDEX_W-1:0]    entry_index_i;
  logic [PREFIX_W-1:0]   entry_prefix_i;
  logic [TEXT_POS_W-1:0] text_position_i;
  logic [KEY_W-1:0]      search_key_i;
  logic [KEY_LEN_W-1:0]  key_length_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  kind_o;
  logic                  found_o;
  logic [INDEX_W-1:0]    first_index_o;
  logic [COUNT_W-1:0]    match_count_o;
  logic [OUT_POS_W-1:0]  position_out_o;
  logic                  truncated_o;
  logic                  last_o;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 51;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned span;

  logic [PREFIX_W-1:0] loaded_prefix [DEPTH_DEF];
  logic [PREFIX_W-1:0] staged [DEPTH_DEF];

  sorted_prefix_range_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .entry_prefix_i (entry_prefix_i),
    .text_position_i(text_position_i),
    .search_key_i   (search_key_i),
    .key_length_i   (key_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .found_o        (found_o),
    .first_index_o  (first_index_o),
    .match_count_o  (match_count_o),
    .position_out_o (position_out_o),
    .truncated_o    (truncated_o),
    .last_o         (last_o)
  );

  srps_listing_checker listing_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .entry_prefix_i (entry_prefix_i),
    .text_position_i(text_position_i),
    .search_key_i   (search_key_i),
    .key_length_i   (key_length_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .found_i        (found_o),
    .first_index_i  (first_index_o),
    .match_count_i  (match_count_o),
    .position_out_i (position_out_o),
    .truncated_i    (truncated_o),
    .last_i         (last_o),
    .failures_o     (mismatches),
    .pending_o      (results_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stalls_served + 1;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [PREFIX_W-1:0] make_prefix();
    logic [PREFIX_W-1:0] v;
    int k;
    v = '0;
    for (k = 0; k < KEY_BYTES_DEF; k++) begin
      v = v << 8;
      if ($urandom_range(0, 7) < 6 - k) begin
        case ($urandom_range(0, 3))
          0: v[7:0] = 8'h00;
          1: v[7:0] = 8'h61;
          2: v[7:0] = 8'h62;
          default: v[7:0] = 8'hFF;
        endcase
      end else begin
        v[7:0] = 8'($urandom_range(0, 255));
      end
    end
    return v;
  endfunction

  task automatic send_request(input logic cmd, input logic [INDEX_W-1:0] idx,
                              input logic [PREFIX_W-1:0] pfx,
                              input logic [TEXT_POS_W-1:0] pos,
                              input logic [KEY_W-1:0] key,
                              input logic [KEY_LEN_W-1:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    entry_index_i <= idx;
    entry_prefix_i <= pfx;
    text_position_i <= pos;
    search_key_i <= key;
    key_length_i <= len;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [PREFIX_W-1:0] pfx,
                           input logic [TEXT_POS_W-1:0] pos);
    loaded_prefix[idx] = pfx;
    send_request(CMD_LOAD, idx, pfx, pos, {$urandom, $urandom},
                 KEY_LEN_W'($urandom_range(0, 15)));
  endtask

  task automatic send_query(input logic [KEY_W-1:0] key, input logic [KEY_LEN_W-1:0] len);
    send_request(CMD_QUERY, INDEX_W'($urandom_range(0, DEPTH_DEF - 1)),
                 {$urandom, $urandom}, $urandom, key, len);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [COUNT_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [COUNT_W-1:0] count_value,
                                  input int unsigned table_size, input bit sorted,
                                  input int unsigned queries, input bit with_hold);
    int unsigned n, q, i, len, pick, slot;
    int j;
    logic [PREFIX_W-1:0] v;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] keep;
    wait_idle();
    write_entry_count(count_value);
    n = (count_value > DEPTH_DEF) ? DEPTH_DEF : count_value;
    if (table_size != 0) begin
      for (i = 0; i < table_size; i++) begin
        if (i != 0 && $urandom_range(0, 7) == 0) staged[i] = staged[i - 1];
        else staged[i] = make_prefix();
      end
      if (sorted) begin
        for (i = 1; i < table_size; i++) begin
          v = staged[i];
          j = i;
          while (j > 0 && staged[j - 1] > v) begin
            staged[j] = staged[j - 1];
            j--;
          end
          staged[j] = v;
        end
      end
      for (i = 0; i < table_size; i++) send_load(INDEX_W'(i), staged[i], $urandom);
    end
    for (q = 0; q < queries; q++) begin
      if (with_hold && q == 3) stall_requests <= stall_requests + 1;
      pick = $urandom_range(0, 99);
      if (pick < 5 && n != 0) begin
        slot = $urandom_range(0, n - 1);
        send_load(INDEX_W'(slot), loaded_prefix[slot], $urandom);
      end else if (pick < 7) begin
        send_load(INDEX_W'($urandom_range(0, DEPTH_DEF - 1)), make_prefix(), $urandom);
      end
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, KEY_BYTES_DEF);
      key = {$urandom, $urandom};
      if (n != 0 && pick < 80) begin
        keep = (len == 0) ? '0 : (~64'h0 << (8 * (KEY_BYTES_DEF - len)));
        key = (loaded_prefix[$urandom_range(0, n - 1)] & keep) | (key & ~keep);
        if (pick >= 65 && len != 0) begin
          v = PREFIX_W'($urandom_range(1, 255));
          key = key ^ (v << (8 * (KEY_BYTES_DEF - $urandom_range(1, len))));
        end
      end
      if (pick >= 92) len = $urandom_range(9, 15);
      send_query(key, KEY_LEN_W'(len));
    end
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    command_i <= CMD_LOAD;
    entry_index_i <= '0;
    entry_prefix_i <= '0;
    text_position_i <= '0;
    search_key_i <= '0;
    key_length_i <= '0;
    for (int k = 0; k < DEPTH_DEF; k++) loaded_prefix[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The entry count is still at its reset value of one here.
    send_load(0, 64'h6162_0000_0000_0000, 32'hFFFF_FFFF);
    send_query(64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_query(64'h6162_1234_5678_9ABC, 2);
    send_query(64'h6163_0000_0000_0000, 2);
    send_query(64'h6161_FFFF_FFFF_FFFF, 8);

    wait_idle();
    write_entry_count(8);
    send_load(0, 64'h0000_0000_0000_0000, 32'h0000_0000);
    send_load(1, 64'h0061_0000_0000_0000, $urandom);
    send_load(2, 64'h6100_0000_0000_0000, $urandom);
    send_load(3, 64'h6162_6300_0000_0000, $urandom);
    send_load(4, 64'h6162_6300_0000_0000, $urandom);
    send_load(5, 64'h6162_64FF_FFFF_FFFF, $urandom);
    send_load(6, 64'h62FF_0000_0000_0001, $urandom);
    send_load(7, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_query(64'h0123_4567_89AB_CDEF, 0);
    send_query(64'h0000_0000_0000_0000, 8);
    send_query(64'h00FF_FFFF_FFFF_FFFF, 1);
    send_query(64'h6162_6355_5555_5555, 3);
    send_query(64'h6162_0000_0000_0000, 2);
    send_query(64'h6100_0000_0000_0000, 8);
    send_query(64'h61AA_AAAA_AAAA_AAAA, 1);
    send_query(64'h6163_0000_0000_0000, 2);
    send_query(64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_query(64'hFFFF_FFFF_FFFF_FFFF, 15);

    wait_idle();
    write_entry_count(0);
    send_query(64'h0000_0000_0000_0000, 0);
    send_query(64'h6162_6300_0000_0000, 3);

    run_random_phase(70, 70, 1'b1, 20, 1'b1);
    send_query({$urandom, $urandom}, 0);
    run_random_phase(50, 0, 1'b1, 8, 1'b0);

    send_idle_pct <= 51;
    recv_idle_pct <= 37;
    span = $urandom_range(2, 24);
    run_random_phase(COUNT_W'(span), span, 1'b1, 15, 1'b0);
    span = $urandom_range(16, 24);
    run_random_phase(COUNT_W'(span), span, 1'b0, 10, 1'b0);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_random_phase(1, 1, 1'b1, 5, 1'b0);
    run_random_phase(16, 16, 1'b1, 10, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/srps_pkg.sv
rtl/core/srps_dp.sv
rtl/core/srps_ctrl.sv
rtl/core/sorted_prefix_range_search.sv
rtl/core/srps_checker.sv
bench/srps_listing_checker.sv
bench/sorted_prefix_range_search_test.sv
